// ----- sv/pats_pkg.sv -----
// Shared types and constants for the priority aging task scheduler.
package pats_pkg;

    typedef logic signed [5:0] t_prio;

    localparam t_prio PRIO_FLOOR = -6'sd20;
    localparam t_prio PRIO_LIMIT = 6'sd20;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SET    = 2'd2,
        CMD_SCHED  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_BUSY   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_RANGE  = 3'd3,
        ST_QEMPTY = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        UPD_NONE   = 3'd0,
        UPD_ADD    = 3'd1,
        UPD_REMOVE = 3'd2,
        UPD_SET    = 3'd3,
        UPD_SCHED  = 3'd4
    } t_upd_op;

    // Update broadcast to every slot cell
    typedef struct packed {
        t_upd_op op;
        t_prio   prio;
    } t_upd;

endpackage

// ----- sv/pats_cell.sv -----
// One task slot: holds its priorities and queue rank, and passes the best candidate on.
module pats_cell
    import pats_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int INDEX     = 0,
    parameter int SW        = 4,
    parameter int RW        = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_upd          i_upd,
    input  logic          i_hit,
    input  logic [RW-1:0] i_ref_rank,
    input  logic [RW-1:0] i_tail_rank,
    input  logic          i_cand_found,
    input  logic [SW-1:0] i_cand_slot,
    input  t_prio         i_cand_dyn,
    input  t_prio         i_cand_stat,
    input  logic [RW-1:0] i_cand_rank,
    output logic          o_cand_found,
    output logic [SW-1:0] o_cand_slot,
    output t_prio         o_cand_dyn,
    output t_prio         o_cand_stat,
    output logic [RW-1:0] o_cand_rank,
    output logic          o_ready,
    output t_prio         o_static,
    output logic [RW-1:0] o_rank
);

    logic          r_ready;
    t_prio         r_static;
    t_prio         r_dyn;
    logic [RW-1:0] r_rank;
    logic          n_ready;
    t_prio         n_static;
    t_prio         n_dyn;
    logic [RW-1:0] n_rank;
    logic          w_take;

    // Lower dynamic priority wins; on a tie the later queue rank wins
    assign w_take = r_ready && (!i_cand_found || (r_dyn < i_cand_dyn) ||
                    ((r_dyn == i_cand_dyn) && (r_rank > i_cand_rank)));

    always_comb begin
        n_ready  = r_ready;
        n_static = r_static;
        n_dyn    = r_dyn;
        n_rank   = r_rank;
        case (i_upd.op)
            UPD_ADD: begin
                if (i_hit) begin
                    n_ready  = 1'b1;
                    n_static = i_upd.prio;
                    n_dyn    = i_upd.prio;
                    n_rank   = i_tail_rank;
                end
            end
            UPD_REMOVE: begin
                if (i_hit) begin
                    n_ready = 1'b0;
                end else if (r_ready && (r_rank > i_ref_rank)) begin
                    n_rank = r_rank - RW'(1);
                end
            end
            UPD_SET: begin
                if (i_hit) begin
                    n_static = i_upd.prio;
                    n_dyn    = i_upd.prio;
                end
            end
            UPD_SCHED: begin
                if (r_ready && i_hit) begin
                    n_dyn  = r_static;
                    n_rank = i_tail_rank;
                end else if (r_ready) begin
                    // age, saturating at the floor, and close the gap behind the pick
                    if (r_dyn > PRIO_FLOOR) begin
                        n_dyn = r_dyn - 6'sd1;
                    end
                    if (r_rank > i_ref_rank) begin
                        n_rank = r_rank - RW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready      <= 1'b0;
            o_cand_found <= 1'b0;
        end else begin
            r_ready      <= n_ready;
            o_cand_found <= i_cand_found || w_take;
        end
        r_static <= n_static;
        r_dyn    <= n_dyn;
        r_rank   <= n_rank;
        if (w_take) begin
            o_cand_slot <= SW'(INDEX);
            o_cand_dyn  <= r_dyn;
            o_cand_stat <= r_static;
            o_cand_rank <= r_rank;
        end else begin
            o_cand_slot <= i_cand_slot;
            o_cand_dyn  <= i_cand_dyn;
            o_cand_stat <= i_cand_stat;
            o_cand_rank <= i_cand_rank;
        end
    end

    assign o_ready  = r_ready;
    assign o_static = r_static;
    assign o_rank   = r_rank;

endmodule

// ----- sv/priority_aging_task_scheduler.sv -----
// Top level of the priority aging task scheduler. Each input beat carries one command
// (add, remove, set priority, schedule) and gives exactly one output beat. Add, remove and
// set priority are applied as the beat is accepted: the addressed slot cell is read and every
// cell updates in the same edge. In a schedule the best candidate ripples down the chain of
// slot cells, one cell per cycle, and the pick, the aging of the other ready slots and the
// queue rotation are applied in the final cycle. One command is in flight at a time; a new
// beat is taken only when the output register is empty or its beat leaves in the same cycle,
// and a finished schedule holds in its final cycle while the output register stays full.
module priority_aging_task_scheduler
    import pats_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // command[1:0], slot[5:2], priority_req[11:6], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // chosen_slot[3:0], chosen_valid[4],
                                       // status_code[7:5], slot_priority[13:8], zero
);

    localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int RW = SW;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] CNT_DONE = CW'(MAX_TASKS);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [3:0]    r_chosen;
    logic [3:0]    n_chosen;
    logic          r_valid;
    logic          n_valid;
    t_status       r_status;
    t_status       n_status;
    t_prio         r_prio;
    t_prio         n_prio;

    t_cmd          w_cmd;
    logic [3:0]    w_slot;
    t_prio         w_req;
    logic          w_in_acc;
    logic          w_out_free;
    logic          w_inside;
    logic          w_in_range;
    logic          w_rd_ready;
    t_prio         w_rd_static;
    logic [RW-1:0] w_rd_rank;
    t_upd          w_upd;
    logic [RW-1:0] w_ref_rank;
    logic [RW-1:0] w_tail_rank;
    logic [SW+3:0] w_tail_ext;

    logic [MAX_TASKS-1:0] w_sel;
    logic [MAX_TASKS-1:0] w_hit;
    logic [MAX_TASKS-1:0] w_ready;
    t_prio                w_static [MAX_TASKS];
    logic [RW-1:0]        w_rank   [MAX_TASKS];

    logic          c_found [MAX_TASKS+1];
    logic [SW-1:0] c_slot  [MAX_TASKS+1];
    t_prio         c_dyn   [MAX_TASKS+1];
    t_prio         c_stat  [MAX_TASKS+1];
    logic [RW-1:0] c_rank  [MAX_TASKS+1];

    assign w_cmd      = t_cmd'(s_axis_tdata[1:0]);
    assign w_slot     = s_axis_tdata[5:2];
    assign w_req      = t_prio'(s_axis_tdata[11:6]);
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_inside   = int'(w_slot) < MAX_TASKS;
    assign w_in_range = (w_req > PRIO_FLOOR) && (w_req < PRIO_LIMIT);
    assign w_tail_ext = {4'b0000, c_slot[MAX_TASKS]};

    // Head of the chain sees no candidate
    assign c_found[0] = 1'b0;
    assign c_slot[0]  = '0;
    assign c_dyn[0]   = '0;
    assign c_stat[0]  = '0;
    assign c_rank[0]  = '0;

    for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
        assign w_sel[k] = int'(w_slot) == k;
        assign w_hit[k] = (r_state == S_SCAN) ? (c_slot[MAX_TASKS] == SW'(k)) : w_sel[k];

        pats_cell #(
            .MAX_TASKS (MAX_TASKS),
            .INDEX     (k),
            .SW        (SW),
            .RW        (RW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_upd        (w_upd),
            .i_hit        (w_hit[k]),
            .i_ref_rank   (w_ref_rank),
            .i_tail_rank  (w_tail_rank),
            .i_cand_found (c_found[k]),
            .i_cand_slot  (c_slot[k]),
            .i_cand_dyn   (c_dyn[k]),
            .i_cand_stat  (c_stat[k]),
            .i_cand_rank  (c_rank[k]),
            .o_cand_found (c_found[k+1]),
            .o_cand_slot  (c_slot[k+1]),
            .o_cand_dyn   (c_dyn[k+1]),
            .o_cand_stat  (c_stat[k+1]),
            .o_cand_rank  (c_rank[k+1]),
            .o_ready      (w_ready[k]),
            .o_static     (w_static[k]),
            .o_rank       (w_rank[k])
        );
    end

    // Read the addressed slot
    always_comb begin
        w_rd_ready  = 1'b0;
        w_rd_static = '0;
        w_rd_rank   = '0;
        for (int k = 0; k < MAX_TASKS; k++) begin
            if (w_sel[k]) begin
                w_rd_ready  = w_rd_ready | w_ready[k];
                w_rd_static = w_rd_static | w_static[k];
                w_rd_rank   = w_rd_rank | w_rank[k];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_count     = r_count;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_chosen    = r_chosen;
        n_valid     = r_valid;
        n_status    = r_status;
        n_prio      = r_prio;
        w_upd.op    = UPD_NONE;
        w_upd.prio  = w_req;
        w_ref_rank  = w_rd_rank;
        w_tail_rank = RW'(r_count);
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_chosen = 4'd0;
                    n_valid  = 1'b0;
                    n_status = ST_OK;
                    n_prio   = '0;
                    case (w_cmd)
                        CMD_ADD: begin
                            n_out_valid = 1'b1;
                            if (!w_inside) begin
                                n_status = ST_BUSY;
                            end else if (w_rd_ready) begin
                                n_status = ST_BUSY;
                                n_prio   = w_rd_static;
                            end else if (!w_in_range) begin
                                n_status = ST_RANGE;
                            end else begin
                                w_upd.op = UPD_ADD;
                                n_count  = r_count + CW'(1);
                                n_prio   = w_req;
                            end
                        end
                        CMD_REMOVE: begin
                            n_out_valid = 1'b1;
                            if (!w_rd_ready) begin
                                n_status = ST_EMPTY;
                            end else begin
                                w_upd.op = UPD_REMOVE;
                                n_count  = r_count - CW'(1);
                                n_prio   = w_rd_static;
                            end
                        end
                        CMD_SET: begin
                            n_out_valid = 1'b1;
                            if (!w_rd_ready) begin
                                n_status = ST_EMPTY;
                            end else if (!w_in_range) begin
                                n_status = ST_RANGE;
                                n_prio   = w_rd_static;
                            end else begin
                                w_upd.op = UPD_SET;
                                n_prio   = w_req;
                            end
                        end
                        CMD_SCHED: begin
                            n_state = S_SCAN;
                            n_cnt   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_cnt != CNT_DONE) begin
                    n_cnt = r_cnt + CW'(1);
                end else if (w_out_free) begin
                    // chain tail now holds the pick over every slot
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    if (c_found[MAX_TASKS]) begin
                        w_upd.op    = UPD_SCHED;
                        w_ref_rank  = c_rank[MAX_TASKS];
                        w_tail_rank = RW'(r_count - CW'(1));
                        n_chosen    = w_tail_ext[3:0];
                        n_valid     = 1'b1;
                        n_status    = ST_OK;
                        n_prio      = c_stat[MAX_TASKS];
                    end else begin
                        n_chosen = 4'd0;
                        n_valid  = 1'b0;
                        n_status = ST_QEMPTY;
                        n_prio   = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_chosen <= n_chosen;
        r_valid  <= n_valid;
        r_status <= n_status;
        r_prio   <= n_prio;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_prio, r_status, r_valid, r_chosen};

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_ready) == int'(r_count))
        else $error("ready count disagrees with ready slots");

    a_pick_is_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_upd.op == UPD_SCHED) |-> w_ready[c_slot[MAX_TASKS]])
        else $error("scheduled slot is not ready");

    a_no_accept_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !w_in_acc)
        else $error("beat accepted during schedule scan");

    a_scan_ends_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && (n_state == S_IDLE)) |=> r_out_valid)
        else $error("schedule finished without a result");

endmodule
